FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the valve setpoint frame scheduler RTL.
// Needs a clock named clk and a reset named rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VSFS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define VSFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/vsfs_pkg.sv
// Package for the valve setpoint frame scheduler: sizes, codes, frame type.
// No dependencies.
package vsfs_pkg;

  localparam int CHANNELS   = 12;
  localparam int GROUP_SIZE = 8;

  localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int GRP_W   = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
  localparam int CH_W    = 4;
  localparam int LEVEL_W = 32;
  localparam int LIMIT_W = 6;
  localparam int BYTE_W  = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(58);
  localparam logic [BYTE_W-1:0]  SEL_BASE    = 8'h80;
  localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(CHANNELS - 1);

  localparam logic REQ_STORE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              chip_select;
    logic [CH_W-1:0]   channel_index;
    logic [BYTE_W-1:0] select_byte;
    logic [BYTE_W-1:0] position;
  } frame_t;

endpackage

FILE: rtl/core/vsfs_frame_fmt.sv
// Frame formatter: clamps a raw setpoint, scales by four, builds chip select
// and one-hot select byte for a channel. Depends on vsfs_pkg.
module vsfs_frame_fmt (
  input  logic [vsfs_pkg::IDX_W-1:0]   idx,
  input  logic [vsfs_pkg::LEVEL_W-1:0] raw,
  input  logic [vsfs_pkg::LIMIT_W-1:0] limit,
  output vsfs_pkg::frame_t             frame
);
  import vsfs_pkg::*;

  logic               neg;
  logic               over;
  logic [LIMIT_W-1:0] clamped;
  logic [GRP_W-1:0]   grp_pos;

  assign neg  = raw[LEVEL_W-1];
  assign over = raw[LEVEL_W-2:0] > (LEVEL_W-1)'(limit);

  always_comb begin
    priority if (neg) begin
      clamped = '0;
    end else if (over) begin
      clamped = limit;
    end else begin
      clamped = raw[LIMIT_W-1:0];
    end
  end

  assign grp_pos = GRP_W'(idx % GROUP_SIZE);

  always_comb begin
    frame.chip_select   = (32'(idx) >= GROUP_SIZE);
    frame.channel_index = CH_W'(idx);
    frame.select_byte   = SEL_BASE >> grp_pos;
    frame.position      = {clamped, 2'b00};
  end

endmodule

FILE: rtl/core/valve_setpoint_frame_scheduler.sv
// Valve setpoint frame scheduler. A store beat (req_type 0) writes a channel's
// requested setpoint and busy stays low. A tick beat (req_type 1) scans the
// 12 channels one per cycle through a single compare and formatter, then
// closes out in a done state, with busy high throughout. Each changed
// channel yields one frame, shown for exactly one cycle with frame_valid;
// the receiver cannot stall, so it must take every frame as it comes. A
// frame is held back until the next changed channel is found or the scan
// ends, so is_last can be marked; frames of one tick may come back to back,
// and the last one appears in the first cycle with busy low. Depends on
// vsfs_pkg, vsfs_frame_fmt and assert_macros.svh.
`include "assert_macros.svh"
module valve_setpoint_frame_scheduler (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           req_type,
  input  logic [vsfs_pkg::CH_W-1:0]      channel,
  input  logic signed [vsfs_pkg::LEVEL_W-1:0] value,
  input  logic                           cfg_write,
  input  logic [vsfs_pkg::LIMIT_W-1:0]   cfg_data,
  output logic                           frame_valid,
  output logic                           chip_select,
  output logic [vsfs_pkg::CH_W-1:0]      channel_index,
  output logic [vsfs_pkg::BYTE_W-1:0]    select_byte,
  output logic [vsfs_pkg::BYTE_W-1:0]    position,
  output logic                           is_last
);
  import vsfs_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   idx_next;
  logic [LIMIT_W-1:0] level_limit;
  logic [LEVEL_W-1:0] req_level [CHANNELS];
  logic [LEVEL_W-1:0] sent_level [CHANNELS];
  logic               have_pend;
  frame_t             pend;
  frame_t             scan_frame;
  logic               scan_hit;
  logic               emit;
  logic               emit_last;
  logic               store_en;
  logic               tick_go;

  vsfs_frame_fmt u_fmt (
    .idx   (idx),
    .raw   (req_level[idx]),
    .limit (level_limit),
    .frame (scan_frame)
  );

  always_comb begin
    state_next = state;
    idx_next   = idx;
    scan_hit   = 1'b0;
    emit       = 1'b0;
    emit_last  = 1'b0;
    store_en   = 1'b0;
    tick_go    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (req_type == REQ_TICK) begin
            tick_go    = 1'b1;
            state_next = ST_SCAN;
            idx_next   = '0;
          end else begin
            store_en = (32'(channel) < CHANNELS);
          end
        end
      end
      ST_SCAN: begin
        scan_hit = (req_level[idx] != sent_level[idx]);
        emit     = scan_hit && have_pend;
        if (idx == LAST_IDX) begin
          state_next = ST_DONE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_DONE: begin
        emit       = have_pend;
        emit_last  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      idx         <= '0;
      level_limit <= LIMIT_RESET;
      have_pend   <= 1'b0;
      frame_valid <= 1'b0;
    end else begin
      state       <= state_next;
      idx         <= idx_next;
      frame_valid <= emit;
      if (cfg_write) begin
        level_limit <= cfg_data;
      end
      if (tick_go) begin
        have_pend <= 1'b0;
      end else if (scan_hit) begin
        have_pend <= 1'b1;
      end
    end
  end

  // level arrays
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        req_level[i]  <= '0;
        sent_level[i] <= '0;
      end
    end else begin
      if (store_en) begin
        req_level[channel[IDX_W-1:0]] <= value;
      end
      if (scan_hit) begin
        sent_level[idx] <= req_level[idx];
      end
    end
  end

  // pending frame and output beat registers
  always_ff @(posedge clk) begin
    if (scan_hit) begin
      pend <= scan_frame;
    end
    if (emit) begin
      chip_select   <= pend.chip_select;
      channel_index <= pend.channel_index;
      select_byte   <= pend.select_byte;
      position      <= pend.position;
      is_last       <= emit_last;
    end
  end

  `VSFS_ASSERT_SAME(a_idx_range, state == ST_SCAN, idx <= LAST_IDX, "scan index out of range")
  `VSFS_ASSERT_SAME(a_mid_busy, frame_valid && !is_last, busy, "non-last frame after scan end")
  `VSFS_ASSERT_SAME(a_last_idle, frame_valid && is_last, !busy, "last frame while still busy")
  `VSFS_ASSERT_SAME(a_sel_onehot, frame_valid, $onehot(select_byte), "select byte not one-hot")
  `VSFS_ASSERT_NEXT(a_tick_clear, tick_go, state == ST_SCAN && !have_pend, "tick did not reset scan")

endmodule

FILE: verif/setpoint_frame_checker.sv
// Checker for the valve setpoint frame scheduler: predicts frames per accepted beat
// and compares every strobed frame with the oldest prediction.
// Depends on vsfs_pkg.
module setpoint_frame_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic                               req_type,
  input  logic [vsfs_pkg::CH_W-1:0]          channel,
  input  logic signed [vsfs_pkg::LEVEL_W-1:0] value,
  input  logic                               cfg_write,
  input  logic [vsfs_pkg::LIMIT_W-1:0]       cfg_data,
  input  logic                               frame_valid,
  input  logic                               chip_select,
  input  logic [vsfs_pkg::CH_W-1:0]          channel_index,
  input  logic [vsfs_pkg::BYTE_W-1:0]        select_byte,
  input  logic [vsfs_pkg::BYTE_W-1:0]        position,
  input  logic                               is_last,
  output int                                 fail_count,
  output int                                 pending
);
  import vsfs_pkg::*;

  typedef struct packed {
    frame_t f;
    logic   last;
  } frame_beat_t;

  logic signed [LEVEL_W-1:0] want_level [CHANNELS];
  logic signed [LEVEL_W-1:0] last_sent  [CHANNELS];
  logic [LIMIT_W-1:0]        clamp_limit;
  frame_beat_t               frames_due [$];

  function automatic logic [BYTE_W-1:0] scaled_position(logic signed [LEVEL_W-1:0] lvl);
    logic [LIMIT_W-1:0] c;
    if (lvl < 0) c = '0;
    else if (lvl > $signed({1'b0, clamp_limit})) c = clamp_limit;
    else c = lvl[LIMIT_W-1:0];
    return {c, 2'b00};
  endfunction

  task automatic schedule_frames();
    int          hits [$];
    frame_beat_t fb;
    int          ch;
    for (int i = 0; i < CHANNELS; i++) begin
      if (last_sent[i] != want_level[i]) hits.push_back(i);
    end
    foreach (hits[k]) begin
      ch = hits[k];
      last_sent[ch]      = want_level[ch];
      fb.f.chip_select   = (ch >= GROUP_SIZE);
      fb.f.channel_index = CH_W'(ch);
      fb.f.select_byte   = SEL_BASE >> (ch % GROUP_SIZE);
      fb.f.position      = scaled_position(last_sent[ch]);
      fb.last            = (k == hits.size() - 1);
      frames_due.push_back(fb);
    end
  endtask

  always @(posedge clk) begin
    frame_beat_t got;
    frame_beat_t want;
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        want_level[i] = '0;
        last_sent[i]  = '0;
      end
      clamp_limit = LIMIT_RESET;
      frames_due.delete();
    end else begin
      if (frame_valid) begin
        got.f.chip_select   = chip_select;
        got.f.channel_index = channel_index;
        got.f.select_byte   = select_byte;
        got.f.position      = position;
        got.last            = is_last;
        if (frames_due.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected frame: cs=%0d ch=%0d sel=%h pos=%0d last=%0d",
                     got.f.chip_select, got.f.channel_index, got.f.select_byte,
                     got.f.position, got.last);
          fail_count++;
        end else begin
          want = frames_due.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $write("frame mismatch: exp cs=%0d ch=%0d sel=%h pos=%0d last=%0d, ",
                     want.f.chip_select, want.f.channel_index, want.f.select_byte,
                     want.f.position, want.last);
              $display("got cs=%0d ch=%0d sel=%h pos=%0d last=%0d",
                       got.f.chip_select, got.f.channel_index, got.f.select_byte,
                       got.f.position, got.last);
            end
            fail_count++;
          end
        end
      end
      if (cfg_write) clamp_limit = cfg_data;
      if (start && !busy) begin
        if (req_type == REQ_STORE) begin
          if (channel < CHANNELS) want_level[channel] = value;
        end else begin
          schedule_frames();
        end
      end
    end
    pending = frames_due.size();
  end

endmodule

FILE: verif/tb.sv
// Top of the valve setpoint frame scheduler testbench: clock, reset, stimulus
// beats, limit register phases, watchdog and verdict.
// Depends on vsfs_pkg, valve_setpoint_frame_scheduler and setpoint_frame_checker.
module tb;
  import vsfs_pkg::*;

  localparam int STALL_LIMIT = 600;
  localparam int SETTLE      = 20;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic                      req_type;
  logic [CH_W-1:0]           channel;
  logic signed [LEVEL_W-1:0] value;
  logic                      cfg_write;
  logic [LIMIT_W-1:0]        cfg_data;
  logic                      frame_valid;
  logic                      chip_select;
  logic [CH_W-1:0]           channel_index;
  logic [BYTE_W-1:0]         select_byte;
  logic [BYTE_W-1:0]         position;
  logic                      is_last;
  int                        fail_count;
  int                        pending;
  int                        idle_cycles;

  valve_setpoint_frame_scheduler i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .channel       (channel),
    .value         (value),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .frame_valid   (frame_valid),
    .chip_select   (chip_select),
    .channel_index (channel_index),
    .select_byte   (select_byte),
    .position      (position),
    .is_last       (is_last)
  );

  setpoint_frame_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .channel       (channel),
    .value         (value),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .frame_valid   (frame_valid),
    .chip_select   (chip_select),
    .channel_index (channel_index),
    .select_byte   (select_byte),
    .position      (position),
    .is_last       (is_last),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (start && !busy) || frame_valid || cfg_write) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[valve_setpoint_frame_scheduler] ERROR");
      $finish;
    end
  end

  // Holds one beat until accepted; returns at the next falling edge with start high.
  task automatic drive_beat(logic rt, logic [CH_W-1:0] ch, logic signed [LEVEL_W-1:0] val);
    start    = 1'b1;
    req_type = rt;
    channel  = ch;
    value    = val;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic store(int ch, logic signed [LEVEL_W-1:0] val);
    drive_beat(REQ_STORE, CH_W'(ch), val);
  endtask

  task automatic tick();
    drive_beat(REQ_TICK, CH_W'($urandom), $urandom);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      start    = 1'b0;
      req_type = 1'($urandom);
      channel  = CH_W'($urandom);
      value    = $urandom;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    pause(1);
    while (pending != 0 || busy) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] lim);
    cfg_write = 1'b1;
    cfg_data  = lim;
    @(negedge clk);
    cfg_write = 1'b0;
    cfg_data  = LIMIT_W'($urandom);
  endtask

  task automatic random_level(output logic signed [LEVEL_W-1:0] val);
    case ($urandom_range(0, 3))
      0: val = $urandom_range(0, 70);
      1: val = -$signed({1'b0, 31'($urandom_range(1, 100))});
      2: val = $urandom;
      default: val = $urandom_range(56, 66);
    endcase
  endtask

  task automatic random_phase(int count);
    int                        done;
    int                        burst;
    int                        pick;
    int                        ch;
    logic signed [LEVEL_W-1:0] val;
    done  = 0;
    burst = $urandom_range(1, 8);
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        tick();
        done++;
      end else begin
        ch = (pick < 30) ? $urandom_range(CHANNELS, 15) : $urandom_range(0, CHANNELS - 1);
        random_level(val);
        store(ch, val);
        done++;
      end
      burst--;
      if (burst == 0) begin
        pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
        burst = $urandom_range(1, 8);
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    req_type  = REQ_STORE;
    channel   = '0;
    value     = '0;
    cfg_write = 1'b0;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: unchanged store, empty tick, extremes, ignored channels, clamp edges
    store(0, 0);
    tick();
    store(0, 10);
    store(7, -1);
    store(8, 32'sh7FFF_FFFF);
    store(11, 32'sh8000_0000);
    store(12, 5);
    store(15, -5);
    store(4, 59);
    tick();
    pause(3);
    for (int i = 0; i < CHANNELS; i++) store(i, i * 6 - 8);
    tick();
    tick();
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_limit(6'd63);
        1: write_limit(6'd0);
        3: write_limit(6'd1);
        default: write_limit(LIMIT_W'($urandom));
      endcase
      random_phase(18);
      wait_drained();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("[valve_setpoint_frame_scheduler] OK");
    end else begin
      $display("[valve_setpoint_frame_scheduler] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/vsfs_pkg.sv
rtl/core/vsfs_frame_fmt.sv
rtl/core/valve_setpoint_frame_scheduler.sv
verif/setpoint_frame_checker.sv
verif/tb.sv
